// ===== design/sobel_edge_map_assert.svh =====
// Assertion macros for the Sobel edge map block.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef SOBEL_EDGE_MAP_ASSERT_SVH
`define SOBEL_EDGE_MAP_ASSERT_SVH

// Same-cycle implication.
`define SEM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sobel_edge_map assertion failed");

// Next-cycle implication.
`define SEM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sobel_edge_map assertion failed");

`endif

// ===== design/sem_pkg.sv =====
// Shared types, constants and functions for the Sobel edge map block.
// No dependencies; the front end, job queue, back end, top level and testbench refer to it by scoped names.
`timescale 1ns / 1ps

package sem_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 1024;
    localparam int CFG_W        = 11;
    localparam int POS_W        = 10;
    localparam int LUMA_W       = 18;
    localparam int LS_W         = 2 * LUMA_W;
    localparam int GRAD_W       = 22;
    localparam int SQ_W         = 2 * GRAD_W;
    localparam int SUM_W        = SQ_W + 1;
    localparam int TH_W         = 21;
    localparam int TSQ_W        = 2 * TH_W;
    localparam int JQ_DEPTH     = 4;
    localparam int JQ_AW        = 2;
    localparam int OQ_DEPTH     = 4;
    localparam int OQ_AW        = 2;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;
    localparam logic [CFG_W-1:0] THRESH_RST = 11'd200;
    localparam logic [CFG_W-1:0] MIN_SIZE   = 11'd3;
    localparam logic [CFG_W-1:0] MAX_W_CFG  = 11'(MAX_WIDTH);
    localparam logic [CFG_W-1:0] MAX_H_CFG  = 11'(MAX_HEIGHT);
    localparam logic [TH_W-1:0]  THRESH_SCALE = 21'd1000;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_WIDTH  = 2'd0;
    localparam t_reg_idx REG_HEIGHT = 2'd1;
    localparam t_reg_idx REG_THRESH = 2'd2;

    // One bit per kind of result a pixel can release.
    typedef logic [3:0] t_kind;
    localparam t_kind KIND_NONE      = 4'b0000;
    localparam t_kind KIND_MAIN      = 4'b0001;
    localparam t_kind KIND_ROW_END   = 4'b0010;
    localparam t_kind KIND_LAST_MAIN = 4'b0100;
    localparam t_kind KIND_LAST_END  = 4'b1000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic             is_edge;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic             frame_last;
    } t_res_out;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [CFG_W-1:0] thresh;
    } t_cfg;

    typedef logic [LUMA_W-1:0] t_luma;
    typedef logic [2:0][2:0][LUMA_W-1:0] t_win;

    typedef struct packed {
        t_win             win;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        t_kind            mask;
        logic             top_mir;
        logic             left_mir;
    } t_job;

    typedef struct packed {
        logic           valid;
        logic [JQ_AW:0] count;
    } t_jq_stat;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } t_grad;

    function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v,
                                                   logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] r;
        r = v;
        if (v < MIN_SIZE) r = MIN_SIZE;
        else if (v > hi) r = hi;
        return r;
    endfunction

    function automatic t_luma calc_luma(t_pix_in p);
        return LUMA_W'(p.red) * 18'd299 + LUMA_W'(p.green) * 18'd587
             + LUMA_W'(p.blue) * 18'd114;
    endfunction

    function automatic t_grad sobel_grad(t_win w, logic [1:0] rt, logic [1:0] rm,
                                         logic [1:0] rb, logic [1:0] cl,
                                         logic [1:0] cm, logic [1:0] cr);
        logic signed [GRAD_W-1:0] tl, tm, tr, ml, mr, bl, bm, br;
        t_grad g;
        tl = $signed(GRAD_W'(w[rt][cl]));
        tm = $signed(GRAD_W'(w[rt][cm]));
        tr = $signed(GRAD_W'(w[rt][cr]));
        ml = $signed(GRAD_W'(w[rm][cl]));
        mr = $signed(GRAD_W'(w[rm][cr]));
        bl = $signed(GRAD_W'(w[rb][cl]));
        bm = $signed(GRAD_W'(w[rb][cm]));
        br = $signed(GRAD_W'(w[rb][cr]));
        g.gx = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
        g.gy = (tl - bl) + ((tm - bm) <<< 1) + (tr - br);
        return g;
    endfunction

endpackage

// ===== design/sem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sem_front.sv =====
// Front end: accepts pixels, forms luma, tracks raster position, runs the
// line stores and the 3x3 window, and emits one job per result-bearing pixel.
// Depends on sem_pkg and sem_ram.
`timescale 1ns / 1ps

module sem_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sem_pkg::t_cfg     i_cfg,
    input  logic              i_push,
    input  sem_pkg::t_pix_in  i_pix,
    output logic              o_full,
    input  sem_pkg::t_jq_stat i_jq,
    output logic              o_jq_push,
    output sem_pkg::t_job     o_job
);

    logic [sem_pkg::CFG_W-1:0] w_w, w_h;
    logic                      w_accept, w_row_end, w_last_row;
    logic [sem_pkg::POS_W-1:0] r_x, r_y;

    logic                      r_s1_valid;
    sem_pkg::t_luma            r_s1_luma;
    logic [sem_pkg::POS_W-1:0] r_s1_x, r_s1_y;
    logic                      r_s1_row_end, r_s1_last;

    logic [sem_pkg::LS_W-1:0]  w_rd;
    sem_pkg::t_win             r_win, n_win;
    sem_pkg::t_kind            w_mask;

    assign w_w = sem_pkg::clamp_size(i_cfg.width, sem_pkg::MAX_W_CFG);
    assign w_h = sem_pkg::clamp_size(i_cfg.height, sem_pkg::MAX_H_CFG);

    // Leave room in the job queue for the item already in stage 1.
    assign o_full   = (int'(i_jq.count) + int'(r_s1_valid)) >= sem_pkg::JQ_DEPTH;
    assign w_accept = i_push & ~o_full;

    assign w_row_end  = {1'b0, r_x} >= (w_w - 11'd1);
    assign w_last_row = {1'b0, r_y} >= (w_h - 11'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x        <= '0;
            r_y        <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                if (w_row_end) begin
                    r_x <= '0;
                    r_y <= w_last_row ? '0 : r_y + 10'd1;
                end else begin
                    r_x <= r_x + 10'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_luma    <= sem_pkg::calc_luma(i_pix);
            r_s1_x       <= r_x;
            r_s1_y       <= r_y;
            r_s1_row_end <= w_row_end;
            r_s1_last    <= w_last_row;
        end
    end

    // Line stores: upper half is the previous row, lower half the row before.
    sem_ram #(
        .WIDTH(sem_pkg::LS_W),
        .DEPTH(sem_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_x),
        .i_wdata ({r_s1_luma, w_rd[sem_pkg::LS_W-1:sem_pkg::LUMA_W]}),
        .i_raddr (r_x),
        .o_rdata (w_rd)
    );

    always_comb begin
        n_win = r_win;
        for (int r = 0; r < 3; r++) begin
            n_win[r][0] = r_win[r][1];
            n_win[r][1] = r_win[r][2];
        end
        n_win[0][2] = w_rd[sem_pkg::LUMA_W-1:0];
        n_win[1][2] = w_rd[sem_pkg::LS_W-1:sem_pkg::LUMA_W];
        n_win[2][2] = r_s1_luma;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    always_comb begin
        w_mask = sem_pkg::KIND_NONE;
        if (r_s1_y != '0) begin
            if (r_s1_x != '0)              w_mask = w_mask | sem_pkg::KIND_MAIN;
            if (r_s1_row_end)              w_mask = w_mask | sem_pkg::KIND_ROW_END;
            if (r_s1_last && r_s1_x != '0) w_mask = w_mask | sem_pkg::KIND_LAST_MAIN;
            if (r_s1_last && r_s1_row_end) w_mask = w_mask | sem_pkg::KIND_LAST_END;
        end
    end

    assign o_jq_push      = r_s1_valid && (w_mask != sem_pkg::KIND_NONE);
    assign o_job.win      = n_win;
    assign o_job.x        = r_s1_x;
    assign o_job.y        = r_s1_y;
    assign o_job.mask     = w_mask;
    assign o_job.top_mir  = (r_s1_y == 10'd1);
    assign o_job.left_mir = (r_s1_x == 10'd1);

endmodule

// ===== design/sem_jobq.sv =====
// Short job queue between the front end and the gradient back end.
// Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_jobq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  sem_pkg::t_job     i_job,
    input  logic              i_pop,
    output sem_pkg::t_job     o_job,
    output sem_pkg::t_jq_stat o_stat
);

    sem_pkg::t_job              r_mem [sem_pkg::JQ_DEPTH];
    logic [sem_pkg::JQ_AW-1:0]  r_wp, r_rp;
    logic [sem_pkg::JQ_AW:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_count <= r_count + (sem_pkg::JQ_AW+1)'(i_push)
                               - (sem_pkg::JQ_AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rp];
    assign o_stat.valid = (r_count != '0);
    assign o_stat.count = r_count;

endmodule

// ===== design/sem_back.sv =====
// Back end: expands each job into its results, computes Sobel gradients,
// squares and compares them to the threshold, and queues results for output.
// Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [sem_pkg::CFG_W-1:0] i_thresh,
    input  sem_pkg::t_job             i_job,
    input  logic                      i_job_valid,
    output logic                      o_job_pop,
    input  logic                      i_pop,
    output logic                      o_empty,
    output sem_pkg::t_res_out         o_res
);

    sem_pkg::t_kind r_done, w_cur, w_sel, w_rest;
    logic           w_credit, w_issue;

    logic [1:0] w_rt, w_rm, w_rb, w_cl, w_cm, w_cr, w_top, w_left;
    logic [sem_pkg::POS_W-1:0] w_px, w_py;
    logic                      w_last;
    sem_pkg::t_grad            w_grad;

    logic                             r_b1_valid, r_b2_valid;
    logic signed [sem_pkg::GRAD_W-1:0] r_b1_gx, r_b1_gy;
    logic [sem_pkg::POS_W-1:0]        r_b1_px, r_b1_py, r_b2_px, r_b2_py;
    logic                             r_b1_last, r_b2_last;
    logic [sem_pkg::SQ_W-1:0]         r_b2_sqx, r_b2_sqy;
    logic [sem_pkg::SUM_W-1:0]        w_sum;

    logic [sem_pkg::TH_W-1:0]  r_t;
    logic [sem_pkg::TSQ_W-1:0] r_tsq;

    sem_pkg::t_res_out         r_oq [sem_pkg::OQ_DEPTH];
    logic [sem_pkg::OQ_AW-1:0] r_owp, r_orp;
    logic [sem_pkg::OQ_AW:0]   r_oq_count;
    logic                      w_oq_pop;

    assign w_cur  = i_job.mask & ~r_done;
    assign w_sel  = w_cur & (~w_cur + 4'd1);
    assign w_rest = w_cur & ~w_sel;

    // Count results already in the pipe against the output queue space.
    assign w_credit = (int'(r_oq_count) + int'(r_b1_valid) + int'(r_b2_valid))
                      < sem_pkg::OQ_DEPTH;
    assign w_issue   = i_job_valid & w_credit;
    assign o_job_pop = w_issue && (w_rest == sem_pkg::KIND_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= sem_pkg::KIND_NONE;
        end else if (w_issue) begin
            r_done <= (w_rest == sem_pkg::KIND_NONE) ? sem_pkg::KIND_NONE
                                                     : (r_done | w_sel);
        end
    end

    // Mirrored borders pick the far row or column in place of the missing one.
    assign w_top  = i_job.top_mir  ? 2'd2 : 2'd0;
    assign w_left = i_job.left_mir ? 2'd2 : 2'd0;

    always_comb begin
        w_rt   = w_top;
        w_rm   = 2'd1;
        w_rb   = 2'd2;
        w_cl   = w_left;
        w_cm   = 2'd1;
        w_cr   = 2'd2;
        w_px   = i_job.x - 10'd1;
        w_py   = i_job.y - 10'd1;
        w_last = 1'b0;
        unique case (w_sel)
            sem_pkg::KIND_MAIN: begin
            end
            sem_pkg::KIND_ROW_END: begin
                w_cl = 2'd1;
                w_cm = 2'd2;
                w_cr = 2'd1;
                w_px = i_job.x;
            end
            sem_pkg::KIND_LAST_MAIN: begin
                w_rt = 2'd1;
                w_rm = 2'd2;
                w_rb = 2'd1;
                w_py = i_job.y;
            end
            sem_pkg::KIND_LAST_END: begin
                w_rt   = 2'd1;
                w_rm   = 2'd2;
                w_rb   = 2'd1;
                w_cl   = 2'd1;
                w_cm   = 2'd2;
                w_cr   = 2'd1;
                w_px   = i_job.x;
                w_py   = i_job.y;
                w_last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_grad = sem_pkg::sobel_grad(i_job.win, w_rt, w_rm, w_rb, w_cl, w_cm, w_cr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
        end else begin
            r_b1_valid <= w_issue;
            r_b2_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_gx   <= w_grad.gx;
        r_b1_gy   <= w_grad.gy;
        r_b1_px   <= w_px;
        r_b1_py   <= w_py;
        r_b1_last <= w_last;
        r_b2_sqx  <= r_b1_gx * r_b1_gx;
        r_b2_sqy  <= r_b1_gy * r_b1_gy;
        r_b2_px   <= r_b1_px;
        r_b2_py   <= r_b1_py;
        r_b2_last <= r_b1_last;
        r_t       <= sem_pkg::TH_W'(i_thresh) * sem_pkg::THRESH_SCALE;
        r_tsq     <= r_t * r_t;
    end

    assign w_sum = sem_pkg::SUM_W'(r_b2_sqx) + sem_pkg::SUM_W'(r_b2_sqy);

    assign w_oq_pop = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp      <= '0;
            r_orp      <= '0;
            r_oq_count <= '0;
        end else begin
            if (r_b2_valid) r_owp <= r_owp + 1'b1;
            if (w_oq_pop)   r_orp <= r_orp + 1'b1;
            r_oq_count <= r_oq_count + (sem_pkg::OQ_AW+1)'(r_b2_valid)
                                     - (sem_pkg::OQ_AW+1)'(w_oq_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b2_valid) begin
            r_oq[r_owp].is_edge    <= w_sum > sem_pkg::SUM_W'(r_tsq);
            r_oq[r_owp].pos_x      <= r_b2_px;
            r_oq[r_owp].pos_y      <= r_b2_py;
            r_oq[r_owp].frame_last <= r_b2_last;
        end
    end

    assign o_empty = (r_oq_count == '0);
    assign o_res   = r_oq[r_orp];

endmodule

// ===== design/sobel_edge_map.sv =====
// Sobel edge map: RGB raster pixels in, per-pixel edge flags with position out.
// Pixels enter on a queue-style port: drive i_pix with push high; the pixel
// transfers on a clock edge where full is low. Results leave the same way:
// while empty is low o_res holds the oldest result, and it transfers on an
// edge where pop is high. Registers (width, height, threshold at 0x0, 0x4,
// 0x8) must be written over the APB port while the block is idle; the user is
// bound by this, as the block does not enforce it. Throughput: one pixel per
// cycle while full is low; a pixel at a row end or on the last row releases
// up to four results, which the gradient back end emits one per cycle while
// the result queue has room, so the front stalls once the job queue fills.
// Results for row y appear once row y+1 reaches the pixel to their right,
// and pass the line store read, job queue, gradient, square and compare stages.
// Reset returns registers to 640x480, threshold 200, and the raster position
// to the top-left corner; line store contents are not cleared and need none.
// When the receiver stops popping, the four-entry result queue and the job
// queue fill in turn and full rises; nothing is dropped.
// Depends on sem_pkg, sem_front, sem_jobq, sem_back and the assertion header.
`timescale 1ns / 1ps
`include "sobel_edge_map_assert.svh"

module sobel_edge_map (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              push,
    input  sem_pkg::t_pix_in  i_pix,
    output logic              full,
    output logic              empty,
    input  logic              pop,
    output sem_pkg::t_res_out o_res
);

    sem_pkg::t_cfg     r_cfg;
    sem_pkg::t_reg_idx w_idx;
    logic              w_cfg_wr;

    logic              w_jq_push, w_jq_pop;
    sem_pkg::t_job     w_job_in, w_job_out;
    sem_pkg::t_jq_stat w_jq_stat;

    assign pready   = 1'b1;
    assign w_idx    = paddr[3:2];
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= sem_pkg::WIDTH_RST;
            r_cfg.height <= sem_pkg::HEIGHT_RST;
            r_cfg.thresh <= sem_pkg::THRESH_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                sem_pkg::REG_WIDTH:  r_cfg.width  <= pwdata[sem_pkg::CFG_W-1:0];
                sem_pkg::REG_HEIGHT: r_cfg.height <= pwdata[sem_pkg::CFG_W-1:0];
                sem_pkg::REG_THRESH: r_cfg.thresh <= pwdata[sem_pkg::CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            sem_pkg::REG_WIDTH:  prdata = 32'(r_cfg.width);
            sem_pkg::REG_HEIGHT: prdata = 32'(r_cfg.height);
            sem_pkg::REG_THRESH: prdata = 32'(r_cfg.thresh);
            default:             prdata = '0;
        endcase
    end

    sem_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_push    (push),
        .i_pix     (i_pix),
        .o_full    (full),
        .i_jq      (w_jq_stat),
        .o_jq_push (w_jq_push),
        .o_job     (w_job_in)
    );

    sem_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_jq_push),
        .i_job   (w_job_in),
        .i_pop   (w_jq_pop),
        .o_job   (w_job_out),
        .o_stat  (w_jq_stat)
    );

    sem_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_thresh    (r_cfg.thresh),
        .i_job       (w_job_out),
        .i_job_valid (w_jq_stat.valid),
        .o_job_pop   (w_jq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (o_res)
    );

    `SEM_ASSERT_NOW(a_jobq_no_overflow, w_jq_push, int'(w_jq_stat.count) < sem_pkg::JQ_DEPTH)
    `SEM_ASSERT_NOW(a_jobq_no_underflow, w_jq_pop, w_jq_stat.valid)
    `SEM_ASSERT_NOW(a_job_has_results, w_jq_push, w_job_in.mask != sem_pkg::KIND_NONE)

endmodule

// ===== tb/sobel_edge_map_tb.sv =====
// Self-checking testbench for the Sobel edge map block: streams RGB rasters,
// predicts every edge result in-bench and checks each popped result in order.
// Depends on sem_pkg for the pixel, result and register index types.
`timescale 1ns / 1ps

module sobel_edge_map_tb;

    localparam int SETTLE_CYCLES = 12;
    localparam int IDLE_LIMIT    = 3000;
    localparam int HOLD_CYCLES   = 300;
    localparam int PIXEL_GOAL    = 310;

    typedef enum logic { STEP_PIXEL, STEP_WRITE } t_step_op;

    typedef struct {
        t_step_op          op;
        sem_pkg::t_reg_idx regi;
        int                value;
        sem_pkg::t_pix_in  pix;
        int                edge_known;  // -1: left to the predictor
    } t_step;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [3:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              push = 1'b0;
    sem_pkg::t_pix_in  i_pix = '0;
    logic              full;
    logic              empty;
    logic              pop = 1'b0;
    sem_pkg::t_res_out o_res;

    sobel_edge_map dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .i_pix   (i_pix),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_res   (o_res)
    );

    always #5 i_clk = ~i_clk;

    // Edge predictor state
    logic [10:0] pred_width, pred_height, pred_thresh;
    logic [17:0] prev_row [sem_pkg::MAX_WIDTH];
    logic [17:0] older_row [sem_pkg::MAX_WIDTH];
    logic [17:0] win [3][3];
    int          col_pos, row_pos;
    sem_pkg::t_res_out edge_expect [$];

    int  errors = 0;
    int  pixels_sent = 0;
    int  results_seen = 0;
    int  reg_writes = 0;
    bit  burst = 0;
    bit  hold_rx = 0;
    bit  run_active = 0;
    int  idle_cycles = 0;
    sem_pkg::t_pix_in last_pix = '0;

    task automatic report(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic longint wv(int r, int c);
        return longint'({46'd0, win[r][c]});
    endfunction

    function automatic bit edge_at(int rt, int rm, int rb, int cl, int cm, int cr);
        longint gx, gy, t;
        gx = (wv(rt, cr) - wv(rt, cl)) + 2 * (wv(rm, cr) - wv(rm, cl))
           + (wv(rb, cr) - wv(rb, cl));
        gy = (wv(rt, cl) - wv(rb, cl)) + 2 * (wv(rt, cm) - wv(rb, cm))
           + (wv(rt, cr) - wv(rb, cr));
        t = longint'(pred_thresh) * 1000;
        return (gx * gx + gy * gy) > (t * t);
    endfunction

    function automatic void add_result(bit e, int px, int py, bit last);
        sem_pkg::t_res_out r;
        r.is_edge    = e;
        r.pos_x      = px[9:0];
        r.pos_y      = py[9:0];
        r.frame_last = last;
        edge_expect.push_back(r);
    endfunction

    function automatic int clamp_dim(logic [10:0] v, int hi);
        if (int'(v) < 3) return 3;
        if (int'(v) > hi) return hi;
        return int'(v);
    endfunction

    // Returns how many results this pixel releases.
    function automatic int predict_pixel(sem_pkg::t_pix_in p);
        int w, h, x, y, idx, top, left, before_n;
        logic [17:0] luma;
        bit row_end, last_row;
        w = clamp_dim(pred_width, sem_pkg::MAX_WIDTH);
        h = clamp_dim(pred_height, sem_pkg::MAX_HEIGHT);
        x = col_pos;
        y = row_pos;
        idx = (x < sem_pkg::MAX_WIDTH) ? x : sem_pkg::MAX_WIDTH - 1;
        luma = 18'(p.red) * 18'd299 + 18'(p.green) * 18'd587 + 18'(p.blue) * 18'd114;
        row_end = (x >= w - 1);
        last_row = (y >= h - 1);
        before_n = edge_expect.size();
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = older_row[idx];
        win[1][2] = prev_row[idx];
        win[2][2] = luma;
        older_row[idx] = prev_row[idx];
        prev_row[idx] = luma;
        if (y >= 1) begin
            top = (y == 1) ? 2 : 0;
            left = (x == 1) ? 2 : 0;
            if (x >= 1) add_result(edge_at(top, 1, 2, left, 1, 2), x - 1, y - 1, 0);
            if (row_end) add_result(edge_at(top, 1, 2, 1, 2, 1), x, y - 1, 0);
            if (last_row) begin
                if (x >= 1) add_result(edge_at(1, 2, 1, left, 1, 2), x - 1, y, 0);
                if (row_end) add_result(edge_at(1, 2, 1, 1, 2, 1), x, y, 1);
            end
        end
        if (row_end) begin
            col_pos = 0;
            row_pos = last_row ? 0 : ((y + 1) & 10'h3FF);
        end else begin
            col_pos = (x + 1) & 10'h3FF;
        end
        return edge_expect.size() - before_n;
    endfunction

    // Offer one pixel; predict it once it transfers.
    task automatic send_pixel(input sem_pkg::t_pix_in p, input int edge_known);
        int gap, n;
        bit taken;
        gap = burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_pix <= p;
        do begin
            @(negedge i_clk);
            taken = !full;
            @(posedge i_clk);
        end while (!taken);
        pixels_sent++;
        last_pix = p;
        n = predict_pixel(p);
        if (edge_known >= 0)
            for (int k = edge_expect.size() - n; k < edge_expect.size(); k++)
                if (edge_expect[k].is_edge != edge_known[0])
                    report($sformatf("directed edge at (%0d,%0d) predicted %0b, table %0d",
                                     edge_expect[k].pos_x, edge_expect[k].pos_y,
                                     edge_expect[k].is_edge, edge_known));
    endtask

    // Hold the sender until every result is out and the pipeline has settled.
    task automatic drain();
        push <= 1'b0;
        while (edge_expect.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_write(input sem_pkg::t_reg_idx regi, input int value);
        logic [31:0] rd;
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {regi, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        rd = prdata;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
        case (regi)
            sem_pkg::REG_WIDTH:  pred_width = value[10:0];
            sem_pkg::REG_HEIGHT: pred_height = value[10:0];
            default:             pred_thresh = value[10:0];
        endcase
        reg_writes++;
        if (rd[10:0] !== value[10:0])
            report($sformatf("register %0d read %0h, wrote %0h", regi, rd, value));
    endtask

    function automatic sem_pkg::t_pix_in random_pixel();
        sem_pkg::t_pix_in p;
        case ($urandom_range(0, 9))
            0, 1: p = last_pix;
            2: p = {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
                    {8{1'($urandom_range(0, 1))}}};
            default: p = 24'($urandom);
        endcase
        return p;
    endfunction

    // Result checker
    initial begin
        sem_pkg::t_res_out got, want;
        int stall;
        bit taken;
        @(posedge i_rst_n);
        forever begin
            if (hold_rx) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 0;
            end
            stall = burst ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do begin
                @(negedge i_clk);
                taken = !empty;
                got = o_res;
                @(posedge i_clk);
            end while (!taken);
            results_seen++;
            if (edge_expect.size() == 0) begin
                report($sformatf("unexpected result at (%0d,%0d)", got.pos_x, got.pos_y));
            end else begin
                want = edge_expect.pop_front();
                if (got.is_edge !== want.is_edge)
                    report($sformatf("is_edge %b, want %b at (%0d,%0d)",
                                     got.is_edge, want.is_edge, want.pos_x, want.pos_y));
                if (got.pos_x !== want.pos_x)
                    report($sformatf("pos_x %0d, want %0d", got.pos_x, want.pos_x));
                if (got.pos_y !== want.pos_y)
                    report($sformatf("pos_y %0d, want %0d", got.pos_y, want.pos_y));
                if (got.frame_last !== want.frame_last)
                    report($sformatf("frame_last %b, want %b at (%0d,%0d)",
                                     got.frame_last, want.frame_last, want.pos_x, want.pos_y));
            end
        end
    end

    // Abort when nothing transfers for too long.
    always @(negedge i_clk) begin
        if (run_active) begin
            if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transfer in %0d cycles", IDLE_LIMIT);
                $display("FAIL sobel_edge_map");
                $finish;
            end
        end
    end

    t_step steps [] = '{
        '{STEP_WRITE, sem_pkg::REG_WIDTH, 0, '0, -1},          // clamps up to 3
        '{STEP_WRITE, sem_pkg::REG_HEIGHT, 3, '0, -1},
        '{STEP_WRITE, sem_pkg::REG_THRESH, 2047, '0, -1},      // nothing can exceed this
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'hFFFFFF, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h000000, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'hFF0000, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h00FF00, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h0000FF, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'hFFFF00, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h00FFFF, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'hFF00FF, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h000000, 0},
        '{STEP_WRITE, sem_pkg::REG_THRESH, 0, '0, -1},  // flat black: gradient 0 is not above 0
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h000000, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h000000, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h000000, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h000000, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h000000, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h000000, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h000000, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h000000, 0},
        '{STEP_PIXEL, sem_pkg::REG_WIDTH, 0, 24'h000000, 0}
    };

    initial begin
        int fw, fh, frames;
        pred_width = sem_pkg::WIDTH_RST;
        pred_height = sem_pkg::HEIGHT_RST;
        pred_thresh = sem_pkg::THRESH_RST;
        for (int i = 0; i < sem_pkg::MAX_WIDTH; i++) begin
            prev_row[i] = '0;
            older_row[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) win[r][c] = '0;
        col_pos = 0;
        row_pos = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_active = 1;

        foreach (steps[i]) begin
            if (steps[i].op == STEP_WRITE) begin
                drain();
                reg_write(steps[i].regi, steps[i].value);
            end else begin
                send_pixel(steps[i].pix, steps[i].edge_known);
            end
        end

        // Oversized frame clamps to the maximum, then shrinks mid-frame.
        drain();
        reg_write(sem_pkg::REG_WIDTH, 2047);
        reg_write(sem_pkg::REG_HEIGHT, 2047);
        reg_write(sem_pkg::REG_THRESH, 150);
        for (int i = 0; i < 6; i++) send_pixel(random_pixel(), -1);
        drain();
        reg_write(sem_pkg::REG_WIDTH, 4);
        send_pixel(random_pixel(), -1);   // past the new last column: wraps
        for (int i = 0; i < 4; i++) send_pixel(random_pixel(), -1);
        drain();
        reg_write(sem_pkg::REG_HEIGHT, 3);
        for (int i = 0; i < 4; i++) send_pixel(random_pixel(), -1);

        frames = 0;
        while (pixels_sent < PIXEL_GOAL) begin
            drain();
            fw = $urandom_range(3, 9);
            fh = $urandom_range(3, 6);
            reg_write(sem_pkg::REG_WIDTH, fw);
            reg_write(sem_pkg::REG_HEIGHT, fh);
            reg_write(sem_pkg::REG_THRESH,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                                  : $urandom_range(0, 700));
            burst = ($urandom_range(0, 3) == 0);
            if (frames == 3) begin
                burst = 1;
                hold_rx = 1;
            end
            for (int i = 0; i < fw * fh; i++) send_pixel(random_pixel(), -1);
            burst = 0;
            frames++;
        end

        drain();
        $display("covered %0d pixels in %0d random frames plus clamp and mid-frame resize",
                 pixels_sent, frames);
        $display("checked %0d results after %0d register writes", results_seen, reg_writes);
        if (errors == 0) begin
            $display("PASS sobel_edge_map");
        end else begin
            $display("FAIL sobel_edge_map");
        end
        $finish;
    end

endmodule
